// File: rtl/core/decimal_display_frame_builder_assert.svh
// Assertion macros for the decimal display frame builder.
// Included by the modules that check their own logic; needs no package.
`ifndef DECIMAL_DISPLAY_FRAME_BUILDER_ASSERT_SVH
`define DECIMAL_DISPLAY_FRAME_BUILDER_ASSERT_SVH
`ifndef ASSERT_OFF
`define DDFB_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define DDFB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DDFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DDFB_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define DDFB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define DDFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/ddfb_pkg.sv
// Shared types, constants and the segment table of the frame builder.
// No dependencies.
`timescale 1ns / 1ps
package ddfb_pkg;

  localparam int CHAIN_LENGTH = 4;
  localparam int DIGIT_COUNT  = 8;
  localparam int FRAME_W      = 64;
  localparam int WORD_W       = 16;
  localparam int SLOT_COUNT   = FRAME_W / WORD_W;
  localparam int VALUE_W      = 32;
  localparam int CHIP_W       = 2;
  localparam int RADDR_W      = 4;
  localparam int CFG_ADDR_W   = 4;
  localparam int CFG_DATA_W   = 32;

  localparam logic [RADDR_W-1:0] ADDR_FIRST_DIGIT = 4'h8;
  localparam logic [RADDR_W-1:0] ADDR_LAST_DIGIT  = 4'h1;
  localparam logic [RADDR_W-1:0] ADDR_INTENSITY   = 4'hA;
  localparam logic [RADDR_W-1:0] ADDR_SCAN_LIMIT  = 4'hB;
  localparam logic [RADDR_W-1:0] ADDR_SHUTDOWN    = 4'hC;

  localparam logic [VALUE_W-1:0] RECIP_10 = 32'hCCCCCCCD;
  localparam int RECIP_SHIFT = 35;

  typedef enum logic {
    MODE_INIT    = 1'b0,
    MODE_DISPLAY = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    REG_INTENSITY  = 2'd0,
    REG_SCAN_LIMIT = 2'd1,
    REG_RUN_ENABLE = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [3:0] intensity;
    logic [2:0] scan_limit;
    logic       run_enable;
  } cfg_regs_t;

  typedef struct packed {
    logic                valid;
    mode_t               mode;
    logic [CHIP_W-1:0]   chip;
    logic [RADDR_W-1:0]  addr;
    logic [VALUE_W-1:0]  quot;
  } cell_link_t;

  typedef struct packed {
    logic               valid;
    logic               last;
    logic [CHIP_W-1:0]  chip;
    logic [WORD_W-1:0]  word;
  } cell_emit_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    unique case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h27;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

// File: rtl/core/ddfb_cell.sv
// One cell of the digit row: splits off one decimal digit, builds one
// register word and hands the rest of the item to its neighbor. Uses ddfb_pkg.
`timescale 1ns / 1ps
module ddfb_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ddfb_pkg::cfg_regs_t  cfg,
  input  ddfb_pkg::cell_link_t link_in,
  output ddfb_pkg::cell_link_t link_out,
  output ddfb_pkg::cell_emit_t emit
);
  import ddfb_pkg::*;

  logic                valid_r;
  mode_t               mode_r;
  logic [CHIP_W-1:0]   chip_r;
  logic [RADDR_W-1:0]  addr_r;
  logic [VALUE_W-1:0]  quot_r;

  logic [2*VALUE_W-1:0] prod;
  logic [VALUE_W-1:0]   quot_div;
  logic [3:0]           ten_lo;
  logic [3:0]           digit;
  logic                 last;
  logic [7:0]           data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= link_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (link_in.valid) begin
      mode_r <= link_in.mode;
      chip_r <= link_in.chip;
      addr_r <= link_in.addr;
      quot_r <= link_in.quot;
    end
  end

  always_comb begin
    prod     = {{VALUE_W{1'b0}}, quot_r} * {{VALUE_W{1'b0}}, RECIP_10};
    quot_div = VALUE_W'(prod[2*VALUE_W-1:RECIP_SHIFT]);
    ten_lo   = 4'({quot_div[0], 3'b000} + {quot_div[2:0], 1'b0});
    digit    = quot_r[3:0] - ten_lo;
  end

  always_comb begin
    if (mode_r == MODE_DISPLAY) begin
      last = (addr_r == ADDR_LAST_DIGIT);
      data = seg_code(digit);
    end else begin
      last = (addr_r == ADDR_SHUTDOWN);
      priority case (addr_r)
        ADDR_INTENSITY:  data = {4'b0, cfg.intensity};
        ADDR_SCAN_LIMIT: data = {5'b0, cfg.scan_limit};
        default:         data = {7'b0, cfg.run_enable};
      endcase
    end
  end

  always_comb begin
    link_out.valid = valid_r && !last;
    link_out.mode  = mode_r;
    link_out.chip  = chip_r;
    link_out.addr  = (mode_r == MODE_DISPLAY) ? addr_r - 4'd1 : addr_r + 4'd1;
    link_out.quot  = quot_div;
    emit.valid     = valid_r;
    emit.last      = last;
    emit.chip      = chip_r;
    emit.word      = {4'h0, addr_r, data};
  end

endmodule

// File: rtl/core/decimal_display_frame_builder.sv
// Frame builder for a daisy chain of LED digit drivers: a start request yields
// 8 display frames or 3 init frames, one frame a cycle, each a strobed beat on
// out_valid that cannot be stalled. Once start is taken, the first frame passes
// the first cell's register and the output register; the rest follow in
// consecutive cycles. The row of 8 digit cells, one cell per frame, sets the
// rate: busy falls in the cycle the item's final cell is active, so a new start
// can be taken in that cycle, back to back. Config is via an APB-style port.
// Depends on ddfb_pkg, ddfb_cell and decimal_display_frame_builder_assert.svh.
`timescale 1ns / 1ps
`include "decimal_display_frame_builder_assert.svh"
module decimal_display_frame_builder #(
  parameter int CHAIN_LENGTH = ddfb_pkg::CHAIN_LENGTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_mode,
  input  logic [ddfb_pkg::CHIP_W-1:0]      in_chip,
  input  logic [ddfb_pkg::VALUE_W-1:0]     in_value,
  output logic                             out_valid,
  output logic [ddfb_pkg::FRAME_W-1:0]     out_frame,
  output logic                             out_last,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [ddfb_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [ddfb_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [ddfb_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import ddfb_pkg::*;

  cfg_regs_t   cfg_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  cell_link_t  link [DIGIT_COUNT+1];
  cell_emit_t  emit [DIGIT_COUNT];
  logic [DIGIT_COUNT-1:0] emit_valid;

  logic        accept;
  logic        sel_valid;
  logic        sel_last;
  logic [CHIP_W-1:0] sel_chip;
  logic [WORD_W-1:0] sel_word;

  logic               out_valid_r;
  logic [FRAME_W-1:0] out_frame_r;
  logic [FRAME_W-1:0] out_frame_nxt;
  logic               out_last_r;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.intensity  <= 4'd3;
      cfg_r.scan_limit <= 3'd7;
      cfg_r.run_enable <= 1'b1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_INTENSITY:  cfg_r.intensity  <= cfg_pwdata[3:0];
        REG_SCAN_LIMIT: cfg_r.scan_limit <= cfg_pwdata[2:0];
        REG_RUN_ENABLE: cfg_r.run_enable <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_INTENSITY:  cfg_prdata = {28'b0, cfg_r.intensity};
      REG_SCAN_LIMIT: cfg_prdata = {29'b0, cfg_r.scan_limit};
      REG_RUN_ENABLE: cfg_prdata = {31'b0, cfg_r.run_enable};
      default:        cfg_prdata = '0;
    endcase
  end

  // feed the cell row
  assign accept = start && !busy;

  always_comb begin
    link[0].valid = accept;
    link[0].mode  = mode_t'(in_mode);
    link[0].chip  = in_chip;
    link[0].addr  = (mode_t'(in_mode) == MODE_DISPLAY) ? ADDR_FIRST_DIGIT
                                                        : ADDR_INTENSITY;
    link[0].quot  = in_value;
  end

  for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_cell
    ddfb_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cfg      (cfg_r),
      .link_in  (link[g]),
      .link_out (link[g+1]),
      .emit     (emit[g])
    );
  end

  // select the one active cell
  always_comb begin
    busy      = 1'b0;
    sel_valid = 1'b0;
    sel_last  = 1'b0;
    sel_chip  = '0;
    sel_word  = '0;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      emit_valid[i] = emit[i].valid;
      busy      = busy | (emit[i].valid & ~emit[i].last);
      sel_valid = sel_valid | emit[i].valid;
      sel_last  = sel_last | (emit[i].valid & emit[i].last);
      sel_chip  = sel_chip | (emit[i].chip & {CHIP_W{emit[i].valid}});
      sel_word  = sel_word | (emit[i].word & {WORD_W{emit[i].valid}});
    end
  end

  // place the word in the target chip's slot
  always_comb begin
    out_frame_nxt = '0;
    for (int c = 0; c < CHAIN_LENGTH; c++) begin
      if (sel_chip == CHIP_W'(c)) begin
        out_frame_nxt[WORD_W*(c+SLOT_COUNT-CHAIN_LENGTH) +: WORD_W] = sel_word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sel_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_frame_r <= out_frame_nxt;
    out_last_r  <= sel_last;
  end

  assign out_valid = out_valid_r;
  assign out_frame = out_frame_r;
  assign out_last  = out_last_r;

  `DDFB_ASSERT_ALWAYS(a_one_cell_active, clk, rst_n, $onehot0(emit_valid))
  `DDFB_ASSERT_ALWAYS(a_row_no_overrun, clk, rst_n, !link[DIGIT_COUNT].valid)
  `DDFB_ASSERT_NEXT(a_accept_enters, clk, rst_n, accept, emit_valid[0] && !busy == 1'b0)
  `DDFB_ASSERT_IMPLY(a_display_ends, clk, rst_n, accept && in_mode, ##9 (out_valid_r && out_last_r))
  `DDFB_ASSERT_IMPLY(a_init_ends, clk, rst_n, accept && !in_mode, ##4 (out_valid_r && out_last_r))

endmodule
